>>> rtl/ibd_pkg.sv
// ----------------------------------------------------------------------------
// ibd_pkg
// shared types and constants of the idle backlight dimmer
// ----------------------------------------------------------------------------
package ibd_pkg;

  localparam int COUNT_W    = 32;
  localparam int LEVEL_W    = 8;
  localparam int FACTOR_W   = 9;
  localparam int LAST_W     = LEVEL_W + 1;
  localparam int PROD_W     = LEVEL_W + FACTOR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0]  COUNT_MAX       = '1;
  localparam logic [LEVEL_W-1:0]  BRIGHT_MAX      = 8'd255;
  localparam logic [LAST_W-1:0]   NOTHING_WRITTEN = 9'd256;

  // register reset values
  localparam logic [COUNT_W-1:0]  RST_DIM_AFTER      = 32'd30000;
  localparam logic [COUNT_W-1:0]  RST_DEEP_AFTER     = 32'd90000;
  localparam logic [FACTOR_W-1:0] RST_DIM_FACTOR     = 9'd128;
  localparam logic [LEVEL_W-1:0]  RST_DIM_FLOOR      = 8'd20;
  localparam logic [FACTOR_W-1:0] RST_DEEP_FACTOR    = 9'd26;
  localparam logic [LEVEL_W-1:0]  RST_DEEP_FLOOR     = 8'd5;
  localparam logic [LEVEL_W-1:0]  RST_USER_BRIGHT    = 8'd255;

  typedef enum logic [1:0] {
    STAGE_BRIGHT = 2'd0,
    STAGE_DIM    = 2'd1,
    STAGE_DEEP   = 2'd2
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_AFTER   = 3'd0,
    REG_DEEP_AFTER  = 3'd1,
    REG_DIM_FACTOR  = 3'd2,
    REG_DIM_FLOOR   = 3'd3,
    REG_DEEP_FACTOR = 3'd4,
    REG_DEEP_FLOOR  = 3'd5,
    REG_USER_BRIGHT = 3'd6
  } cfg_reg_t;

endpackage

>>> rtl/idle_backlight_dimmer.sv
// ----------------------------------------------------------------------------
// idle_backlight_dimmer
// two-stage idle dimmer: idle ms counter, stage tracking, brightness output
// ----------------------------------------------------------------------------
// Each input item is a one-millisecond tick (kind 0) or a key press (kind 1)
// with a flag telling whether the backlight is powered. Ticks advance a
// saturating 32-bit idle counter and a key press clears it; while powered,
// the counter picks the bright, dim or deep dim stage from two thresholds,
// and a key press returns to bright. On a stage change the block emits the new
// brightness, unless it equals the last value emitted. An item is latched in
// an input register and resolved by one pass of logic (a 32-bit increment
// and compares, one 8x9 multiply with clamps) into the output register when
// it is free or draining, so one item is taken every cycle while the output
// is not stalled. The input register also acts as a skid stage: one item is
// still taken while a result waits for out_ready.
// Configuration is a plain write port, registers 0..6 in the order dim
// threshold, deep dim threshold, dim factor, dim lower limit, deep dim factor,
// deep dim lower limit, user level; index 7 is ignored.
// ----------------------------------------------------------------------------
module idle_backlight_dimmer
  import ibd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // item input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic                  in_backlight_on,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_W-1:0]    out_brightness,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [COUNT_W-1:0]  dim_after_r;
  logic [COUNT_W-1:0]  deep_after_r;
  logic [FACTOR_W-1:0] dim_factor_r;
  logic [LEVEL_W-1:0]  dim_floor_r;
  logic [FACTOR_W-1:0] deep_factor_r;
  logic [LEVEL_W-1:0]  deep_floor_r;
  logic [LEVEL_W-1:0]  user_bright_r;

  // input register
  logic s1_valid_r;
  logic s1_kind_r;
  logic s1_powered_r;

  // block state
  logic [COUNT_W-1:0] idle_count_r, idle_count_nxt;
  stage_t             stage_r, stage_nxt;
  logic [LAST_W-1:0]  last_written_r, last_written_nxt;

  // output register
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_bright_r;

  logic               fire;
  logic               emit;
  logic               change;
  stage_t             want;
  logic [COUNT_W-1:0] count_inc;
  logic [LEVEL_W-1:0] target;
  logic [FACTOR_W-1:0] sel_factor;
  logic [LEVEL_W-1:0]  sel_floor;
  logic [PROD_W-1:0]   prod;
  logic [LEVEL_W:0]    scaled;
  logic [LEVEL_W-1:0]  clamped;
  logic [LEVEL_W-1:0]  floored;

  // second stage moves when the output register is free or draining
  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  assign out_valid      = out_valid_r;
  assign out_brightness = out_bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_after_r   <= RST_DIM_AFTER;
      deep_after_r  <= RST_DEEP_AFTER;
      dim_factor_r  <= RST_DIM_FACTOR;
      dim_floor_r   <= RST_DIM_FLOOR;
      deep_factor_r <= RST_DEEP_FACTOR;
      deep_floor_r  <= RST_DEEP_FLOOR;
      user_bright_r <= RST_USER_BRIGHT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIM_AFTER:   dim_after_r   <= cfg_wdata[COUNT_W-1:0];
        REG_DEEP_AFTER:  deep_after_r  <= cfg_wdata[COUNT_W-1:0];
        REG_DIM_FACTOR:  dim_factor_r  <= cfg_wdata[FACTOR_W-1:0];
        REG_DIM_FLOOR:   dim_floor_r   <= cfg_wdata[LEVEL_W-1:0];
        REG_DEEP_FACTOR: deep_factor_r <= cfg_wdata[FACTOR_W-1:0];
        REG_DEEP_FLOOR:  deep_floor_r  <= cfg_wdata[LEVEL_W-1:0];
        REG_USER_BRIGHT: user_bright_r <= cfg_wdata[LEVEL_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // stage decision
  always_comb begin
    count_inc = (idle_count_r == COUNT_MAX) ? idle_count_r : idle_count_r + 1'b1;
    if (s1_kind_r) begin
      // key press: clear count, back to bright when powered
      idle_count_nxt = '0;
      want           = STAGE_BRIGHT;
    end else begin
      idle_count_nxt = count_inc;
      if (count_inc >= deep_after_r) begin
        want = STAGE_DEEP;
      end else if (count_inc >= dim_after_r) begin
        want = STAGE_DIM;
      end else begin
        want = STAGE_BRIGHT;
      end
    end
    change = s1_powered_r && (want != stage_r);
  end

  // target level for the wanted stage
  always_comb begin
    case (want)
      STAGE_DEEP: begin
        sel_factor = deep_factor_r;
        sel_floor  = deep_floor_r;
      end
      default: begin
        sel_factor = dim_factor_r;
        sel_floor  = dim_floor_r;
      end
    endcase
    prod    = {{FACTOR_W{1'b0}}, user_bright_r} * {{LEVEL_W{1'b0}}, sel_factor};
    scaled  = prod[PROD_W-1:FACTOR_W-1];
    clamped = scaled[LEVEL_W] ? BRIGHT_MAX : scaled[LEVEL_W-1:0];
    floored = (clamped < sel_floor) ? sel_floor : clamped;
    if (want == STAGE_BRIGHT) begin
      target = user_bright_r;
    end else begin
      target = (floored > user_bright_r) ? user_bright_r : floored;
    end
  end

  // state update and emit decision
  always_comb begin
    emit             = change && ({1'b0, target} != last_written_r);
    stage_nxt        = change ? want : stage_r;
    last_written_nxt = emit ? {1'b0, target} : last_written_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      idle_count_r   <= '0;
      stage_r        <= STAGE_BRIGHT;
      last_written_r <= NOTHING_WRITTEN;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (fire) begin
        idle_count_r   <= idle_count_nxt;
        stage_r        <= stage_nxt;
        last_written_r <= last_written_nxt;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r    <= in_kind;
      s1_powered_r <= in_backlight_on;
    end
    if (fire && emit) begin
      out_bright_r <= target;
    end
  end

endmodule

>>> rtl/ibd_checker.sv
// ----------------------------------------------------------------------------
// ibd_checker
// port-level checks of the idle backlight dimmer, bound to the top level
// ----------------------------------------------------------------------------
module ibd_checker
  import ibd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_kind,
  input logic                  in_backlight_on,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_W-1:0]    out_brightness
);

  logic               seen_r;
  logic [LEVEL_W-1:0] prev_r;

  // last brightness delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_r <= out_brightness;
    end
  end

  // no result is shown in the cycle after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with no result pending the input side is always open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a delivered level never repeats the previous one
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && seen_r) |-> (out_brightness != prev_r))
    else $error("same brightness delivered twice in a row");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_brightness)))
    else $error("stalled result changed");

  // a waiting item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(in_kind) && $stable(in_backlight_on)))
    else $error("waiting item changed");

endmodule

bind idle_backlight_dimmer ibd_checker u_ibd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_kind         (in_kind),
  .in_backlight_on (in_backlight_on),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_brightness  (out_brightness)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the two-stage idle backlight dimmer
// ----------------------------------------------------------------------------
// Sends streams of millisecond ticks and key presses, some powered and some
// not. Each phase starts from a fresh set of register values. A cycle-free
// model of the dimmer predicts every brightness write as items are accepted.
// Results are compared in order. Random gaps on the sender side and random
// stalls on the receiver side move the timing around.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ibd_pkg::*;

  // item kinds and the index past the register list
  localparam logic                 KIND_TICK  = 1'b0;
  localparam logic                 KIND_KEY   = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int SETTLE_CYCLES = 8;     // covers the input and output registers with margin
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake before giving up

  typedef struct {
    logic        kind;
    logic        powered;
    int unsigned lead_gap;   // idle cycles the sender waits before this item
  } dimmer_event_t;

  // dut connections; the ones the bench drives are known from time zero
  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic                  in_kind         = 1'b0;
  logic                  in_backlight_on = 1'b0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic [LEVEL_W-1:0]    out_brightness;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata       = '0;

  // stimulus and expected writes
  dimmer_event_t        pending_events[$];
  logic [LEVEL_W-1:0]   pending_levels[$];

  // shadow copy of the register file, starting at the reset values
  logic [COUNT_W-1:0]  m_dim_after   = RST_DIM_AFTER;
  logic [COUNT_W-1:0]  m_deep_after  = RST_DEEP_AFTER;
  logic [FACTOR_W-1:0] m_dim_factor  = RST_DIM_FACTOR;
  logic [LEVEL_W-1:0]  m_dim_floor   = RST_DIM_FLOOR;
  logic [FACTOR_W-1:0] m_deep_factor = RST_DEEP_FACTOR;
  logic [LEVEL_W-1:0]  m_deep_floor  = RST_DEEP_FLOOR;
  logic [LEVEL_W-1:0]  m_user        = RST_USER_BRIGHT;

  // shadow of the dimmer state
  logic [COUNT_W-1:0]  idle_ms    = '0;
  stage_t              cur_stage  = STAGE_BRIGHT;
  logic [LAST_W-1:0]   last_level = NOTHING_WRITTEN;

  // bookkeeping
  int unsigned errors     = 0;
  int unsigned n_events   = 0;
  int unsigned n_results  = 0;
  int unsigned n_phases   = 0;
  int unsigned n_writes   = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned quiet      = 0;
  bit          calm       = 1'b0;   // when set, neither side idles

  idle_backlight_dimmer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_backlight_on (in_backlight_on),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_brightness  (out_brightness),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // brightness model
  // --------------------------------------------------------------------------

  // brightness wanted in a stage: bright is the user level, dim stages scale
  // it, clamp to full scale, lift to the floor and then cap at the user level
  function automatic logic [LEVEL_W-1:0] stage_level(input stage_t st);
    logic [FACTOR_W-1:0] factor;
    logic [LEVEL_W-1:0]  floor_lv;
    int unsigned         lv;
    if (st == STAGE_BRIGHT) return m_user;
    factor   = (st == STAGE_DIM) ? m_dim_factor : m_deep_factor;
    floor_lv = (st == STAGE_DIM) ? m_dim_floor  : m_deep_floor;
    lv = (32'(m_user) * 32'(factor)) >> 8;   // truncating q1.8 multiply
    if (lv > BRIGHT_MAX) lv = 32'(BRIGHT_MAX);
    if (lv < floor_lv) lv = 32'(floor_lv);
    if (lv > m_user) lv = 32'(m_user);       // cap wins over the floor
    return lv[LEVEL_W-1:0];
  endfunction

  // stage always moves; a write only goes out when the level really changes
  function automatic void move_to_stage(input stage_t st);
    logic [LEVEL_W-1:0] lv;
    lv = stage_level(st);
    cur_stage = st;
    if ({1'b0, lv} != last_level) begin
      last_level = {1'b0, lv};
      pending_levels.push_back(lv);
    end
  endfunction

  // one accepted item: update the idle count and maybe the stage
  function automatic void predict_brightness(input logic kind, input logic powered);
    stage_t want;
    if (kind == KIND_KEY) begin
      idle_ms = '0;
      if (powered && cur_stage != STAGE_BRIGHT) move_to_stage(STAGE_BRIGHT);
    end else begin
      if (idle_ms != COUNT_MAX) idle_ms = idle_ms + 1'b1;
      // an unpowered backlight keeps its stage, only the count moves
      if (powered) begin
        // deep threshold checked first, so it wins even below the dim one
        if (idle_ms >= m_deep_after)     want = STAGE_DEEP;
        else if (idle_ms >= m_dim_after) want = STAGE_DIM;
        else                             want = STAGE_BRIGHT;
        if (want != cur_stage) move_to_stage(want);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // sender: one item at a time from the pending queue, with drawn gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : tx_side
    dimmer_event_t ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_brightness(in_kind, in_backlight_on);
        n_events++;
      end
      if (in_valid && !in_ready) begin
        // item not taken yet, hold valid and payload
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_events.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_events[0].lead_gap != 0) begin
        // start the gap in front of the next item, it counts this cycle
        gap_left <= pending_events[0].lead_gap - 1;
        pending_events[0].lead_gap = 0;
        in_valid <= 1'b0;
      end else begin
        ev = pending_events.pop_front();
        in_valid        <= 1'b1;
        in_kind         <= ev.kind;
        in_backlight_on <= ev.powered;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: check each write against the oldest prediction, then stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rx_side
    int unsigned        draw;
    logic [LEVEL_W-1:0] want_level;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      n_results++;
      if (pending_levels.size() == 0) begin
        $display("%0t unexpected brightness write: expected none, got %0d",
                 $time, out_brightness);
        errors++;
      end else begin
        want_level = pending_levels.pop_front();
        if (out_brightness !== want_level) begin
          $display("%0t brightness mismatch: expected %0d, got %0d",
                   $time, want_level, out_brightness);
          errors++;
        end
      end
      draw = calm ? 0 : $urandom_range(0, 8);
      stall_left <= draw;
      out_ready  <= (draw == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any handshake means the block is stuck
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t no handshake for %0d cycles, %0d writes still expected",
               $time, QUIET_LIMIT, pending_levels.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // one register write through the port, mirrored into the shadow registers
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_writes++;
    case (idx)
      REG_DIM_AFTER:   m_dim_after   = val;
      REG_DEEP_AFTER:  m_deep_after  = val;
      REG_DIM_FACTOR:  m_dim_factor  = val[FACTOR_W-1:0];
      REG_DIM_FLOOR:   m_dim_floor   = val[LEVEL_W-1:0];
      REG_DEEP_FACTOR: m_deep_factor = val[FACTOR_W-1:0];
      REG_DEEP_FLOOR:  m_deep_floor  = val[LEVEL_W-1:0];
      REG_USER_BRIGHT: m_user        = val[LEVEL_W-1:0];
      default: ;       // past the list, the block ignores it
    endcase
  endtask

  // full register set for a phase, plus a stray write past the list
  task automatic program_regs(
    input logic [31:0] dim_after,  input logic [31:0] deep_after,
    input logic [31:0] dim_scale,  input logic [31:0] dim_min,
    input logic [31:0] deep_factor, input logic [31:0] deep_floor,
    input logic [31:0] user_level);
    write_reg(REG_DIM_AFTER, dim_after);
    write_reg(REG_DEEP_AFTER, deep_after);
    write_reg(REG_DIM_FACTOR, dim_scale);
    write_reg(REG_DIM_FLOOR, dim_min);
    write_reg(REG_DEEP_FACTOR, deep_factor);
    write_reg(REG_DEEP_FLOOR, deep_floor);
    write_reg(REG_USER_BRIGHT, user_level);
    write_reg(REG_UNUSED, $urandom);
    n_phases++;
  endtask

  function automatic void add_event(input logic kind, input logic powered);
    dimmer_event_t ev;
    ev.kind     = kind;
    ev.powered  = powered;
    ev.lead_gap = calm ? 0 : $urandom_range(0, 8);
    pending_events.push_back(ev);
  endfunction

  // mostly runs of powered ticks closed by a key press, so the count climbs
  // through both thresholds; unpowered items and odd keys mixed in as noise
  function automatic void queue_events(input int unsigned count);
    int unsigned run;
    while (pending_events.size() < count) begin
      run = $urandom_range(0, 14);
      repeat (run) add_event(KIND_TICK, $urandom_range(0, 9) != 0);
      add_event(KIND_KEY, $urandom_range(0, 4) != 0);
    end
  endfunction

  // sender drained, every write seen, then a settle wait for items in flight
  // that cause no write
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || pending_levels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: short thresholds with the default dim factors
    program_regs(3, 6, 128, 20, 26, 5, 255);
    @(negedge clk);
    repeat (4) add_event(KIND_TICK, 1'b0);   // unpowered, count moves only
    add_event(KIND_TICK, 1'b1);              // dim
    add_event(KIND_TICK, 1'b1);              // deep dim
    add_event(KIND_KEY, 1'b0);               // clears count, stage stays
    add_event(KIND_TICK, 1'b0);
    add_event(KIND_TICK, 1'b1);              // below dim again: bright
    add_event(KIND_TICK, 1'b1);              // dim
    add_event(KIND_KEY, 1'b1);               // back to bright
    add_event(KIND_KEY, 1'b1);               // already bright, nothing
    repeat (6) add_event(KIND_TICK, 1'b1);   // through dim into deep dim
    add_event(KIND_KEY, 1'b1);
    wait_idle();

    // full-scale dim factor clamps and gets capped, zero deep factor with zero floor
    program_regs(1, 2, 511, 0, 0, 0, 200);
    @(negedge clk);
    queue_events(25);
    wait_idle();

    // deep threshold below dim; floors above the user level; deep dim
    // lands on the bright level so the stage moves without a write
    calm = 1'b1;
    program_regs(5, 2, 0, 255, 511, 255, 100);
    @(negedge clk);
    queue_events(25);
    wait_idle();
    calm = 1'b0;

    // zero dim threshold and zero user level: every stage gives zero
    program_regs(0, 4, 256, 10, 64, 0, 0);
    @(negedge clk);
    queue_events(25);
    wait_idle();

    // thresholds at the top of the range are never reached
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, $urandom, $urandom,
                 $urandom, 255);
    @(negedge clk);
    queue_events(25);
    wait_idle();

    // random settings; wide write data also exercises masking of the
    // narrow registers
    for (int ph = 0; ph < 7; ph++) begin
      calm = (ph % 3 == 2);
      program_regs($urandom_range(1, 12), $urandom_range(1, 16), $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      @(negedge clk);
      queue_events(55);
      wait_idle();
    end

    if (pending_levels.size() != 0) begin
      $display("%0t %0d brightness writes never arrived", $time, pending_levels.size());
      errors++;
    end

    $display("covered %0d phases, %0d register writes, %0d ticks and key presses",
             n_phases, n_writes, n_events);
    $display("checked %0d brightness writes, %0d errors", n_results, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
